// ----- rtl/rilp_pkg.sv -----
// ----------------------------------------------------------------------------
// Radix integer literal parser package
// Shared types, character codes and the byte step functions used by the
// parser core and its speculative prefix lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package rilp_pkg;

  localparam int AccW    = 32;
  localparam int MaxBase = 36;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] CaseBit  = 8'h20;

  localparam logic [5:0] BaseChar = 6'd1;
  localparam logic [5:0] BaseOct  = 6'd8;
  localparam logic [5:0] BaseDec  = 6'd10;
  localparam logic [5:0] BaseHex  = 6'd16;

  typedef enum logic [1:0] {
    CcNone = 2'd0,
    CcWait = 2'd1,
    CcDone = 2'd2
  } cc_phase_e;

  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [5:0]      base;
    logic            fixed;
    logic            neg;
    logic            err;
    cc_phase_e       phase;
  } rilp_state_t;

  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            neg;
    logic            err;
  } rilp_lane_t;

  typedef struct packed {
    logic step;
    logic late;
    logic clear;
  } rilp_lane_ctl_t;

  typedef struct packed {
    rilp_lane_t hex;
    rilp_lane_t oct;
    rilp_lane_t hexoct;
  } rilp_lanes_t;

  // Bit 6 flags a digit character, bits 5:0 hold its value.
  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= ChZero && c <= ChNine) begin
      r = {1'b1, 6'(c - ChZero)};
    end else if (c >= ChLowA && c <= ChLowZ) begin
      r = {1'b1, 6'(c - ChLowA + 8'd10)};
    end else if (c >= ChUpA && c <= ChUpZ) begin
      r = {1'b1, 6'(c - ChUpA + 8'd10)};
    end
    return r;
  endfunction

  function automatic rilp_state_t idle_state();
    rilp_state_t r;
    r.acc   = '0;
    r.base  = BaseDec;
    r.fixed = 1'b0;
    r.neg   = 1'b0;
    r.err   = 1'b0;
    r.phase = CcNone;
    return r;
  endfunction

  function automatic rilp_state_t take_byte(input rilp_state_t s, input logic [7:0] c);
    rilp_state_t       r;
    logic [6:0]        dv;
    logic [AccW+5:0]   prod;
    r    = s;
    dv   = digit_of(c);
    prod = (AccW+6)'(s.acc) * (AccW+6)'(s.base);
    if (s.err || s.phase == CcDone) begin
      r = s;
    end else if (s.phase == CcWait) begin
      r.acc   = AccW'(c);
      r.phase = CcDone;
    end else if (c == ChMinus) begin
      r.neg = 1'b1;
    end else if (c == ChHash) begin
      if (s.fixed || s.acc == '0 || s.acc > AccW'(MaxBase)) begin
        r.err = 1'b1;
      end else begin
        r.base = s.acc[5:0];
        if (s.acc == AccW'(1)) begin
          r.phase = CcWait;
        end else begin
          r.acc   = '0;
          r.fixed = 1'b1;
        end
      end
    end else if (!dv[6] || dv[5:0] >= s.base) begin
      r.err = 1'b1;
    end else begin
      r.acc = prod[AccW-1:0] + AccW'(dv[5:0]);
    end
    return r;
  endfunction

  // Fixed-base step: a hash is always an error since the base is fixed.
  function automatic rilp_lane_t lane_step(input rilp_lane_t s, input logic [7:0] c,
                                           input logic sh16);
    rilp_lane_t r;
    logic [6:0] dv;
    logic [5:0] base;
    r    = s;
    dv   = digit_of(c);
    base = sh16 ? BaseHex : BaseOct;
    if (!s.err) begin
      if (c == ChMinus) begin
        r.neg = 1'b1;
      end else if (!dv[6] || dv[5:0] >= base) begin
        r.err = 1'b1;
      end else if (sh16) begin
        r.acc = {s.acc[AccW-5:0], 4'b0} + AccW'(dv[5:0]);
      end else begin
        r.acc = {s.acc[AccW-4:0], 3'b0} + AccW'(dv[5:0]);
      end
    end
    return r;
  endfunction

  function automatic rilp_state_t lane_to_state(input rilp_lane_t l, input logic [5:0] base);
    rilp_state_t r;
    r.acc   = l.acc;
    r.base  = base;
    r.fixed = 1'b1;
    r.neg   = l.neg;
    r.err   = l.err;
    r.phase = CcNone;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rilp_prefix_lanes.sv -----
// ----------------------------------------------------------------------------
// Speculative prefix lanes
// Three fixed-base accumulators that run alongside the main parser while the
// prefix is still open: hex from the third byte, octal from the first byte,
// and octal after a hex prefix from the third byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rilp_prefix_lanes (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  rilp_pkg::rilp_lane_ctl_t ctl_i,
  input  wire  [7:0]              ch_i,
  output rilp_pkg::rilp_lanes_t   view_o
);
  import rilp_pkg::*;

  rilp_lanes_t lanes_q, lanes_d, stepped;

  always_comb begin
    stepped.hex    = ctl_i.late ? lane_step(lanes_q.hex, ch_i, 1'b1) : lanes_q.hex;
    stepped.oct    = lane_step(lanes_q.oct, ch_i, 1'b0);
    stepped.hexoct = ctl_i.late ? lane_step(lanes_q.hexoct, ch_i, 1'b0) : lanes_q.hexoct;
  end

  assign view_o = ctl_i.step ? stepped : lanes_q;

  always_comb begin
    lanes_d = lanes_q;
    if (ctl_i.clear) begin
      lanes_d = '0;
    end else if (ctl_i.step) begin
      lanes_d = stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '0;
    end else begin
      lanes_q <= lanes_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/radix_integer_literal_parser.sv -----
// ----------------------------------------------------------------------------
// Radix integer literal parser
// Parses a numeric string, one byte per word, with hex, octal and N# base
// prefixes and the 1#c character-code form, and returns one result word
// when the end-of-string word arrives.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Content
//  in       input      in_valid_i/in_ready_o   ch, end_of_string, arith_mode, zero_fill
//  out      output     out_valid_o/out_ready_i status, base_used, value
//  cfg      input      cfg_valid_i/cfg_ready_o posix_mode
//
// One input word is taken per cycle; a result appears in the cycle after its end
// word. The path is one 32x6 multiply-accumulate plus a prefix select.
// The first four bytes also feed three fixed-base lanes so the prefix choice
// is a select, not a replay. Input stalls only while a result waits unread.
// Reset sets posix_mode to 0 and clears all but the held bytes and result fields.
`default_nettype none

module radix_integer_literal_parser (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire  [7:0]               ch_i,
  input  wire                      end_of_string_i,
  input  wire                      arith_mode_i,
  input  wire                      zero_fill_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic                     status_o,
  output logic [5:0]               base_used_o,
  output logic [rilp_pkg::AccW-1:0] value_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire                      cfg_data_i
);
  import rilp_pkg::*;

  logic            posix_q;
  logic [2:0]      pos_q, pos_d;
  logic [1:0]      mode_q;
  logic [7:0]      buf_q [3];
  rilp_state_t     eng_q, eng_d, eng_view, sel, fin;
  logic            out_valid_q;
  logic            status_q;
  logic [5:0]      base_q;
  logic [AccW-1:0] value_q;

  logic            fire, take, open_pfx, decide;
  logic            arith, zf, hex, oct;
  logic [7:0]      hb0, hb1, hb2, hb3, b_off, b_next;
  logic [6:0]      next_dv;
  rilp_lane_ctl_t  lane_ctl;
  rilp_lanes_t     lanes;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_i && in_ready_o;
  assign take        = fire && !end_of_string_i;
  assign open_pfx    = pos_q < 3'd4;
  assign decide      = open_pfx && (end_of_string_i || pos_q == 3'd3);

  assign arith = (pos_q == 3'd0) ? arith_mode_i : mode_q[0];
  assign zf    = (pos_q == 3'd0) ? zero_fill_i  : mode_q[1];

  // Held bytes read as zero when absent, which matches no prefix test.
  assign hb0 = (pos_q > 3'd0) ? buf_q[0] : 8'h00;
  assign hb1 = (pos_q > 3'd1) ? buf_q[1] : 8'h00;
  assign hb2 = (pos_q > 3'd2) ? buf_q[2] : 8'h00;
  assign hb3 = end_of_string_i ? 8'h00 : ch_i;

  assign hex     = arith && hb0 == ChZero && (hb1 | CaseBit) == ChLowX;
  assign b_off   = hex ? hb2 : hb0;
  assign b_next  = hex ? hb3 : hb1;
  assign next_dv = digit_of(b_next);
  assign oct     = posix_q && arith && !zf && b_off == ChZero &&
                   next_dv[6] && b_next <= ChNine;

  assign lane_ctl.step  = take && open_pfx;
  assign lane_ctl.late  = pos_q >= 3'd2;
  assign lane_ctl.clear = fire && end_of_string_i;

  rilp_prefix_lanes u_lanes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .ch_i   (ch_i),
    .view_o (lanes)
  );

  assign eng_view = take ? take_byte(eng_q, ch_i) : eng_q;

  always_comb begin
    case ({hex, oct})
      2'b10:   sel = lane_to_state(lanes.hex, BaseHex);
      2'b01:   sel = lane_to_state(lanes.oct, BaseOct);
      2'b11:   sel = lane_to_state(lanes.hexoct, BaseOct);
      default: sel = eng_view;
    endcase
  end

  assign fin = open_pfx ? sel : eng_q;

  always_comb begin
    eng_d = eng_q;
    pos_d = pos_q;
    if (fire && end_of_string_i) begin
      eng_d = idle_state();
      pos_d = 3'd0;
    end else if (take) begin
      eng_d = decide ? sel : eng_view;
      if (open_pfx) begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posix_q     <= 1'b0;
      pos_q       <= 3'd0;
      mode_q      <= 2'b00;
      eng_q       <= idle_state();
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        posix_q <= cfg_data_i;
      end
      pos_q <= pos_d;
      eng_q <= eng_d;
      if (fire && pos_q == 3'd0) begin
        mode_q <= {zero_fill_i, arith_mode_i};
      end
      if (fire && end_of_string_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pos_q < 3'd3) begin
      buf_q[pos_q[1:0]] <= ch_i;
    end
    if (fire && end_of_string_i) begin
      status_q <= fin.err;
      if (fin.err) begin
        base_q  <= 6'd0;
        value_q <= '0;
      end else if (fin.phase != CcNone) begin
        base_q  <= BaseChar;
        value_q <= (fin.phase == CcDone) ? fin.acc : '0;
      end else begin
        base_q  <= fin.base;
        value_q <= fin.neg ? (~fin.acc + AccW'(1)) : fin.acc;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign base_used_o = base_q;
  assign value_o     = value_q;

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 3'd4) else $error("byte position out of range");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_of_string_i |=> out_valid_o) else $error("end word gave no result");

  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !out_valid_o |=> !out_valid_o) else $error("result without end word");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> base_used_o == 6'd0 && value_o == '0)
    else $error("error result carries data");

  a_ok_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_o |-> base_used_o >= 6'd1 && base_used_o <= 6'd36)
    else $error("base out of range");

endmodule

`default_nettype wire

// ----- bench/tb_radix_integer_literal_parser.sv -----
// ----------------------------------------------------------------------------
// Radix integer literal parser testbench
// Sends numeric strings one byte word at a time under random sender bursts
// and receiver stalls. Each accepted word runs through a local model of the
// parser; every result word is checked field by field against the model, or
// against the fixed word that a directed row gives. A short directed table
// comes first; random strings follow in phases with posix_mode clear and set.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_radix_integer_literal_parser;

  timeunit 1ns;
  timeprecision 1ps;

  import rilp_pkg::*;

  localparam int CycleLimit  = 250000;
  localparam int PhaseWords  = 140;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic            status;
    logic [5:0]      base;
    logic [AccW-1:0] value;
  } lit_t;

  typedef struct {
    logic [7:0] c;
    logic       e;
    logic       a;
    logic       z;
    logic       fixed;
    lit_t       fix;
  } stim_row_t;

  typedef enum logic [1:0] {
    RdyAlways = 2'd0,
    RdyCoin   = 2'd1,
    RdySlow   = 2'd2,
    RdyToggle = 2'd3
  } rdy_mode_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      ch_i = 8'h00;
  logic            end_of_string_i = 1'b0;
  logic            arith_mode_i = 1'b0;
  logic            zero_fill_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic            status_o;
  logic [5:0]      base_used_o;
  logic [AccW-1:0] value_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_data_i = 1'b0;

  radix_integer_literal_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ch_i            (ch_i),
    .end_of_string_i (end_of_string_i),
    .arith_mode_i    (arith_mode_i),
    .zero_fill_i     (zero_fill_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .base_used_o     (base_used_o),
    .value_o         (value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Parser model state.
  logic            posix_cfg;
  logic [AccW-1:0] acc;
  logic [5:0]      radix;
  logic            radix_locked;
  logic            minus_seen;
  logic            bad;
  logic [7:0]      held_bytes [4];
  logic [2:0]      held_cnt;
  cc_phase_e       cc;
  logic            lat_arith;
  logic            lat_zf;

  lit_t            pending_lits [$];
  stim_row_t       stim_rows [$];
  logic [7:0]      lit_bytes [$];
  string           noise_set = "0123456789afxzAFXZ-#_ ";
  int              lit_fail_cnt = 0;
  int              burst_left = 0;
  int              random_words = 0;
  int              cycle_cnt = 0;
  rdy_mode_e       rdy_mode = RdyAlways;
  int              rdy_hold = 0;

  function automatic lit_t mk_lit(input logic st, input logic [5:0] b,
                                  input logic [AccW-1:0] v);
    lit_t r;
    r.status = st;
    r.base   = b;
    r.value  = v;
    return r;
  endfunction

  function automatic void clear_lit();
    int i;
    acc          = '0;
    radix        = BaseDec;
    radix_locked = 1'b0;
    minus_seen   = 1'b0;
    bad          = 1'b0;
    for (i = 0; i < 4; i++) held_bytes[i] = 8'h00;
    held_cnt     = 3'd0;
    cc           = CcNone;
    lat_arith    = 1'b0;
    lat_zf       = 1'b0;
  endfunction

  function automatic void fold_byte(input logic [7:0] c);
    logic [5:0] dig;
    logic       is_dig;
    dig    = '0;
    is_dig = 1'b1;
    if (c >= ChZero && c <= ChNine) begin
      dig = 6'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      dig = 6'(c - ChLowA + 8'd10);
    end else if (c >= ChUpA && c <= ChUpZ) begin
      dig = 6'(c - ChUpA + 8'd10);
    end else begin
      is_dig = 1'b0;
    end
    if (bad || cc == CcDone) begin
      // Nothing changes once the string has failed or its code is taken.
    end else if (cc == CcWait) begin
      acc = AccW'(c);
      cc  = CcDone;
    end else if (c == ChMinus) begin
      minus_seen = 1'b1;
    end else if (c == ChHash) begin
      if (radix_locked || acc == '0 || acc > AccW'(MaxBase)) begin
        bad = 1'b1;
      end else begin
        radix = acc[5:0];
        if (acc == AccW'(1)) begin
          cc = CcWait;
        end else begin
          acc          = '0;
          radix_locked = 1'b1;
        end
      end
    end else if (!is_dig || dig >= radix) begin
      bad = 1'b1;
    end else begin
      acc = acc * AccW'(radix) + AccW'(dig);
    end
  endfunction

  function automatic logic [7:0] held_at(input int i, input int n);
    return (i < n && i < 4) ? held_bytes[i] : 8'h00;
  endfunction

  function automatic void resolve_prefix(input int n);
    int         off;
    int         i;
    logic [7:0] nx;
    off = 0;
    if (lat_arith && held_at(0, n) == ChZero && (held_at(1, n) | CaseBit) == ChLowX) begin
      off          = 2;
      radix        = BaseHex;
      radix_locked = 1'b1;
    end
    nx = held_at(off + 1, n);
    if (posix_cfg && lat_arith && held_at(off, n) == ChZero && nx >= ChZero &&
        nx <= ChNine && !lat_zf) begin
      radix        = BaseOct;
      radix_locked = 1'b1;
    end
    for (i = off; i < n && i < 4; i++) fold_byte(held_bytes[i]);
    held_cnt = 3'd4;
  endfunction

  function automatic void parse_word(input logic [7:0] c, input logic e, input logic a,
                                     input logic z, output logic got, output lit_t r);
    got = 1'b0;
    r   = '0;
    if (held_cnt == 3'd0) begin
      lat_arith = a;
      lat_zf    = z;
    end
    if (!e) begin
      if (held_cnt < 3'd4) begin
        held_bytes[held_cnt[1:0]] = c;
        held_cnt = held_cnt + 3'd1;
        if (held_cnt == 3'd4) resolve_prefix(4);
      end else begin
        fold_byte(c);
      end
    end else begin
      if (held_cnt < 3'd4) resolve_prefix(int'(held_cnt));
      got = 1'b1;
      if (bad) begin
        r = mk_lit(1'b1, 6'd0, '0);
      end else if (cc != CcNone) begin
        r = mk_lit(1'b0, BaseChar, (cc == CcDone) ? acc : '0);
      end else begin
        r = mk_lit(1'b0, radix, minus_seen ? -acc : acc);
      end
      clear_lit();
    end
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic e, input logic a,
                                  input logic z, input logic fixed, input lit_t fix);
    stim_row_t r;
    r.c     = c;
    r.e     = e;
    r.a     = a;
    r.z     = z;
    r.fixed = fixed;
    r.fix   = fix;
    stim_rows.push_back(r);
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return ChZero + 8'(d);
    if ($urandom_range(0, 1) == 0) return ChLowA + 8'(d - 10);
    return ChUpA + 8'(d - 10);
  endfunction

  function automatic void note_mismatch(input string what, input lit_t want, input lit_t got);
    lit_fail_cnt++;
    if (lit_fail_cnt <= 10) begin
      $display("%0t %s: expected status=%0d base=%0d value=%h, got status=%0d base=%0d value=%h",
               $realtime, what, want.status, want.base, want.value,
               got.status, got.base, got.value);
    end
  endfunction

  task automatic push_word(input logic [7:0] c, input logic e, input logic a, input logic z,
                           input logic fixed, input lit_t fix);
    int   gap;
    logic got;
    lit_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    ch_i            <= c;
    end_of_string_i <= e;
    arith_mode_i    <= a;
    zero_fill_i     <= z;
    do @(posedge clk_i); while (!in_ready_o);
    parse_word(c, e, a, z, got, r);
    if (got) begin
      if (fixed) r = fix;
      pending_lits.push_back(r);
    end
  endtask

  task automatic set_posix(input logic v);
    in_valid_i <= 1'b0;
    while (pending_lits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    posix_cfg = v;
  endtask

  task automatic make_literal(output logic a, output logic z);
    int kind;
    int n;
    int b;
    int i;
    lit_bytes.delete();
    a    = ($urandom_range(0, 3) != 0);
    z    = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      n = $urandom_range(0, 11);
      for (i = 0; i < n; i++) lit_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) lit_bytes.insert($urandom_range(0, n), ChMinus);
    end else if (kind < 35) begin
      lit_bytes.push_back(ChZero);
      lit_bytes.push_back(($urandom_range(0, 1) == 0) ? ChLowX : (ChLowX & ~CaseBit));
      n = $urandom_range(0, 9);
      for (i = 0; i < n; i++) lit_bytes.push_back(digit_char($urandom_range(0, 15)));
    end else if (kind < 45) begin
      lit_bytes.push_back(ChZero);
      n = $urandom_range(0, 7);
      for (i = 0; i < n; i++) begin
        b = ($urandom_range(0, 9) == 0) ? 9 : 7;
        lit_bytes.push_back(ChZero + 8'($urandom_range(0, b)));
      end
    end else if (kind < 65) begin
      b = $urandom_range(2, MaxBase);
      if (b >= 10) lit_bytes.push_back(ChZero + 8'(b / 10));
      lit_bytes.push_back(ChZero + 8'(b % 10));
      lit_bytes.push_back(ChHash);
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) lit_bytes.push_back(digit_char($urandom_range(0, b - 1)));
      if ($urandom_range(0, 3) == 0) begin
        lit_bytes.insert($urandom_range(0, lit_bytes.size()), ChMinus);
      end
    end else if (kind < 75) begin
      if ($urandom_range(0, 4) == 0) lit_bytes.push_back(ChMinus);
      lit_bytes.push_back(ChZero + 8'd1);
      lit_bytes.push_back(ChHash);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) lit_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      case ($urandom_range(0, 2))
        0: begin
          b = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MaxBase + 1, 99);
          if (b >= 10) lit_bytes.push_back(ChZero + 8'(b / 10));
          lit_bytes.push_back(ChZero + 8'(b % 10));
          lit_bytes.push_back(ChHash);
          lit_bytes.push_back(ChZero);
        end
        1: begin
          b = $urandom_range(2, 9);
          lit_bytes.push_back(ChZero + 8'(b));
          lit_bytes.push_back(ChHash);
          lit_bytes.push_back(digit_char($urandom_range(0, b - 1)));
          lit_bytes.push_back(ChHash);
          lit_bytes.push_back(ChZero);
        end
        default: begin
          b = $urandom_range(2, MaxBase - 1);
          if (b >= 10) lit_bytes.push_back(ChZero + 8'(b / 10));
          lit_bytes.push_back(ChZero + 8'(b % 10));
          lit_bytes.push_back(ChHash);
          lit_bytes.push_back(digit_char($urandom_range(b, MaxBase - 1)));
        end
      endcase
    end else begin
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 3) begin
          lit_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          lit_bytes.push_back(noise_set[$urandom_range(0, noise_set.len() - 1)]);
        end
      end
    end
  endtask

  task automatic send_literal();
    logic a;
    logic z;
    int   i;
    make_literal(a, z);
    for (i = 0; i < lit_bytes.size(); i++) begin
      push_word(lit_bytes[i], 1'b0, (i == 0) ? a : 1'($urandom_range(0, 1)),
                (i == 0) ? z : 1'($urandom_range(0, 1)), 1'b0, '0);
    end
    push_word(8'($urandom_range(0, 255)), 1'b1,
              (lit_bytes.size() == 0) ? a : 1'($urandom_range(0, 1)),
              (lit_bytes.size() == 0) ? z : 1'($urandom_range(0, 1)), 1'b0, '0);
    random_words += lit_bytes.size() + 1;
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rdy_hold == 0) begin
      rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      rdy_hold <= $urandom_range(8, 60);
    end else begin
      rdy_hold <= rdy_hold - 1;
    end
    case (rdy_mode)
      RdyAlways: out_ready_i <= 1'b1;
      RdyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
      RdySlow:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= ~out_ready_i;
    endcase
  end

  always @(posedge clk_i) begin : check_lit
    lit_t got;
    lit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = mk_lit(status_o, base_used_o, value_o);
      if (pending_lits.size() == 0) begin
        note_mismatch("unexpected result word", '0, got);
      end else begin
        want = pending_lits.pop_front();
        if (got !== want) note_mismatch("result word mismatch", want, got);
      end
    end
  end

  initial begin : run_test
    int i;
    int phase;
    clear_lit();
    posix_cfg = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_posix(1'b1);

    add_row(8'hA5, 1'b1, 1'b0, 1'b0, 1'b1, mk_lit(1'b0, BaseDec, '0));
    add_row("0", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row("x", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row("F", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row("f", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b1, mk_lit(1'b0, BaseHex, 32'hFF));
    add_row("0", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row("1", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row("7", 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, mk_lit(1'b0, BaseOct, 32'd15));
    add_row("0", 1'b0, 1'b1, 1'b1, 1'b0, '0);
    add_row("7", 1'b0, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, '0);
    add_row("1", 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row("#", 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b1, 1'b0, 1'b0, 1'b1, mk_lit(1'b0, BaseChar, '0));
    add_row("-", 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row("5", 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, mk_lit(1'b0, BaseDec, 32'hFFFF_FFFB));
    add_row(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, mk_lit(1'b1, 6'd0, '0));
    add_row("3", 1'b0, 1'b0, 1'b1, 1'b0, '0);
    add_row("6", 1'b0, 1'b0, 1'b1, 1'b0, '0);
    add_row("#", 1'b0, 1'b0, 1'b1, 1'b0, '0);
    add_row("Z", 1'b0, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0);

    for (i = 0; i < stim_rows.size(); i++) begin
      push_word(stim_rows[i].c, stim_rows[i].e, stim_rows[i].a, stim_rows[i].z,
                stim_rows[i].fixed, stim_rows[i].fix);
    end

    for (phase = 0; phase < 3; phase++) begin
      set_posix(phase == 1);
      random_words = 0;
      while (random_words < PhaseWords) send_literal();
    end

    in_valid_i <= 1'b0;
    while (pending_lits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (lit_fail_cnt == 0 && pending_lits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
